>>> hdl/u8u16_pkg.sv
// shared types and constants for the utf-8 to utf-16 decoder
package u8u16_pkg;

    // default width of the per-buffer code unit counter
    localparam int COUNT_WIDTH_DEFAULT = 24;

    // field widths fixed by the interface
    localparam int BYTE_W   = 8;
    localparam int UNIT_W   = 16;
    localparam int LIMIT_W  = 24;
    localparam int SUMCNT_W = 24;
    localparam int PART_W   = 10;

    // depth of the result queue, in transaction records
    localparam int RES_DEPTH = 2;

    // lead byte classification
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;

    // reason decoding stopped within a buffer
    typedef enum logic [1:0] {
        CAUSE_NONE      = 2'd0,
        CAUSE_BAD_LEAD  = 2'd1,
        CAUSE_TRUNCATED = 2'd2,
        CAUSE_LIMIT     = 2'd3
    } stop_cause_t;

    // everything one input byte produces: an optional unit and an optional summary
    typedef struct packed {
        logic                has_unit;
        logic [UNIT_W-1:0]   code_unit;
        logic                has_sum;
        logic [SUMCNT_W-1:0] unit_count;
        stop_cause_t         stop_cause;
    } result_rec_t;

endpackage

>>> hdl/utf8_to_utf16_decoder.sv
// utf-8 to utf-16 decoder: byte decode, per-buffer state and result queue
// output: each result is registered in the result queue and offered from its head
// throughput: one byte per cycle while the result queue is not full; a byte that
//   yields a unit and a summary is sent as two output transactions and may fill the queue
// reset: asynchronous, active low; clears decode state, unit limit and the queue
module utf8_to_utf16_decoder #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [u8u16_pkg::LIMIT_W-1:0] cfg_wr_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [u8u16_pkg::BYTE_W-1:0]  in_byte,
    input  logic                          end_of_buffer,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic [u8u16_pkg::UNIT_W-1:0]  code_unit,
    output logic [u8u16_pkg::SUMCNT_W-1:0] unit_count,
    output logic [1:0]                    stop_cause,
    output logic                          last_of_run
);
    import u8u16_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam int PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int CNT_W = $clog2(RES_DEPTH + 1);
    localparam logic [CNT_W-1:0] QUEUE_FULL = CNT_W'(RES_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(RES_DEPTH - 1);

    // configuration and decode state
    logic [LIMIT_W-1:0]     unit_limit_reg;
    logic [1:0]             pending_reg, pending_next;
    logic [PART_W-1:0]      partial_reg, partial_next;
    logic                   stopped_reg, stopped_next;
    stop_cause_t            reason_reg, reason_next;
    logic [COUNT_WIDTH-1:0] units_reg, units_next;

    // decode scratch
    logic                   have_unit;
    logic [UNIT_W-1:0]      unit_val;
    logic [UNIT_W-1:0]      cont_val;
    result_rec_t            rec_new;
    logic                   in_fire;
    logic                   push;

    // result queue
    result_rec_t            res_mem [RES_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   unit_sent_reg;
    result_rec_t            head;
    logic                   unit_phase;
    logic                   out_fire;
    logic                   pop;

    assign in_stall = (count_reg == QUEUE_FULL);
    assign in_fire  = in_valid && !in_stall;

    // byte decode against the current sequence state
    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        stopped_next = stopped_reg;
        reason_next  = reason_reg;
        units_next   = units_reg;
        have_unit    = 1'b0;
        unit_val     = '0;
        cont_val     = {partial_reg, in_byte[5:0]};
        if (!stopped_reg)
        begin
            priority if (pending_reg != 2'd0)
            begin
                pending_next = pending_reg - 2'd1;
                if (pending_reg == 2'd1)
                begin
                    unit_val     = cont_val;
                    partial_next = '0;
                    have_unit    = 1'b1;
                end
                else
                begin
                    partial_next = cont_val[PART_W-1:0];
                end
            end
            else if (!in_byte[7])
            begin
                unit_val  = {8'h00, in_byte};
                have_unit = 1'b1;
            end
            else if ((in_byte & LEAD2_MASK) == LEAD2_CODE)
            begin
                partial_next = {5'b0, in_byte[4:0]};
                pending_next = 2'd1;
            end
            else if ((in_byte & LEAD3_MASK) == LEAD3_CODE)
            begin
                partial_next = {6'b0, in_byte[3:0]};
                pending_next = 2'd2;
            end
            else
            begin
                stopped_next = 1'b1;
                reason_next  = CAUSE_BAD_LEAD;
            end

            // count the unit and check the limit
            if (have_unit)
            begin
                if (units_reg != {COUNT_WIDTH{1'b1}})
                begin
                    units_next = units_reg + 1'b1;
                end
                if ((unit_limit_reg != '0) && (CMP_W'(units_next) == CMP_W'(unit_limit_reg)))
                begin
                    stopped_next = 1'b1;
                    reason_next  = CAUSE_LIMIT;
                end
            end

            // buffer ends inside a sequence
            if (end_of_buffer && !stopped_next && (pending_next != 2'd0))
            begin
                stopped_next = 1'b1;
                reason_next  = CAUSE_TRUNCATED;
            end
        end

        rec_new.has_unit   = have_unit;
        rec_new.code_unit  = unit_val;
        rec_new.has_sum    = end_of_buffer;
        rec_new.unit_count = SUMCNT_W'(units_next);
        rec_new.stop_cause = stopped_next ? reason_next : CAUSE_NONE;
    end

    assign push = in_fire && (have_unit || end_of_buffer);

    // unit limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_limit_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unit_limit_reg <= cfg_wr_data;
        end
    end

    // per-buffer decode state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            stopped_reg <= 1'b0;
            reason_reg  <= CAUSE_NONE;
            units_reg   <= '0;
        end
        else if (in_fire)
        begin
            if (end_of_buffer)
            begin
                pending_reg <= 2'd0;
                partial_reg <= '0;
                stopped_reg <= 1'b0;
                reason_reg  <= CAUSE_NONE;
                units_reg   <= '0;
            end
            else
            begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
                stopped_reg <= stopped_next;
                reason_reg  <= reason_next;
                units_reg   <= units_next;
            end
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_mem[wr_ptr_reg] <= rec_new;
        end
    end

    // head record presented as one or two output transactions
    assign head       = res_mem[rd_ptr_reg];
    assign out_valid  = (count_reg != '0);
    assign unit_phase = head.has_unit && !unit_sent_reg;
    assign kind       = !unit_phase;
    assign code_unit  = unit_phase ? head.code_unit : '0;
    assign unit_count = unit_phase ? '0 : head.unit_count;
    assign stop_cause = unit_phase ? CAUSE_NONE : head.stop_cause;
    assign last_of_run = unit_phase ? !head.has_sum : 1'b1;
    assign out_fire   = out_valid && !out_stall;
    assign pop        = out_fire && last_of_run;

    // occupancy after this cycle's push and pop
    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // queue pointers and unit phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            unit_sent_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (out_fire)
            begin
                unit_sent_reg <= !pop;
            end
        end
    end

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_FULL)
        else $error("result queue occupancy beyond depth");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_buffer) |=> (units_reg == '0 && pending_reg == 2'd0 && !stopped_reg))
        else $error("buffer state not cleared after final byte");

    a_stop_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> (reason_reg != CAUSE_NONE))
        else $error("stopped without a cause");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind) |-> last_of_run)
        else $error("summary not marked last of run");

    a_unit_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind) |-> (unit_count == '0 && stop_cause == CAUSE_NONE))
        else $error("unit transaction carries summary fields");

endmodule
